// File: hdl/mini_x86_instruction_executor_defines.svh
// Assertion macros shared by the executor RTL.
`ifndef MINI_X86_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define MINI_X86_INSTRUCTION_EXECUTOR_DEFINES_SVH

`ifndef SYNTH
// clocked check, off while reset is asserted
`define MXIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also live during reset
`define MXIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MXIE_ASSERT(lbl, prop, msg)
`define MXIE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/mxie_pkg.sv
package mxie_pkg;

  localparam int PC_W     = 18;
  localparam int NREGS    = 17;
  localparam int SP_ID    = 6;
  localparam int FLAGS_ID = 16;

  localparam logic [31:0] FLAG_CF = 32'h1;
  localparam logic [31:0] FLAG_ZF = 32'h40;
  localparam logic [31:0] FLAG_SF = 32'h80;
  localparam logic [31:0] FLAG_OF = 32'h800;

  typedef enum logic [4:0] {
    OP_SUBI  = 5'd0,
    OP_ADD   = 5'd1,
    OP_ADDI  = 5'd2,
    OP_MUL   = 5'd3,
    OP_SHR   = 5'd4,
    OP_MOV   = 5'd5,
    OP_LOAD  = 5'd6,
    OP_STORE = 5'd7,
    OP_IMM   = 5'd8,
    OP_CMP   = 5'd9,
    OP_JE    = 5'd10,
    OP_JL    = 5'd11,
    OP_JLE   = 5'd12,
    OP_JGE   = 5'd13,
    OP_JBE   = 5'd14,
    OP_JMP   = 5'd15,
    OP_CALL  = 5'd16,
    OP_RET   = 5'd17,
    OP_PUSH  = 5'd18,
    OP_POP   = 5'd19,
    OP_PRINT = 5'd20,
    OP_READ  = 5'd21
  } op_t;

endpackage

// File: hdl/mxie_in_if.sv
interface mxie_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        instruction_word;
  logic signed [31:0] read_value;

  modport source(output valid, output instruction_word, output read_value, input ready);
  modport sink(input valid, input instruction_word, input read_value, output ready);
endinterface

// File: hdl/mxie_out_if.sv
interface mxie_out_if;
  logic                       valid;
  logic                       ready;
  logic [mxie_pkg::PC_W-1:0]  next_pc;
  logic                       print_valid;
  logic signed [31:0]         print_value;
  logic                       halted;

  modport source(output valid, output next_pc, output print_valid, output print_value,
                 output halted, input ready);
  modport sink(input valid, input next_pc, input print_valid, input print_value,
               input halted, output ready);
endinterface

// File: hdl/mini_x86_instruction_executor.sv
// Channel   Dir  Payload                                       Handshake
// in_chan   in   instruction_word, read_value                  valid/ready
// out_chan  out  next_pc, print_valid, print_value, halted     valid/ready
// cfg       in   cfg_wr_data (program length in words)         cfg_wr_en
//
// One instruction per cycle while the result side is not stalled. An accepted
// word moves into the execute register (operands read from the register file
// at transfer), then into the result register, where the byte-banked stack
// memory returns load data. Loads, pop and ret finish in the result stage and
// are forwarded to the next instruction. Reset (synchronous, rst_n low) clears
// PC, halt, pipeline and register file, but sets SP to MEM_BYTES. A stalled
// result holds both stages; the input stays open while the execute register is
// empty or moves on. MEM_BYTES must be a power of two.
`include "mini_x86_instruction_executor_defines.svh"

module mini_x86_instruction_executor #(
  parameter int MEM_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  mxie_in_if.sink           in_chan,
  mxie_out_if.source        out_chan
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int ROWS = MEM_BYTES / 4;
  localparam int RW   = AW - 2;
  localparam int PW   = mxie_pkg::PC_W;

  // configuration
  logic [15:0]   prog_len_r;
  logic [PW-1:0] end_pc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr_en) begin
      prog_len_r <= cfg_wr_data;
    end
  end
  assign end_pc = {prog_len_r, 2'b00};

  // architectural state
  logic [PW-1:0] pc_r;
  logic          halt_r;
  logic [31:0]   rf_r [mxie_pkg::NREGS];

  // execute stage
  logic          s1_valid_r;
  logic [31:0]   s1_word_r;
  logic [31:0]   s1_rv_r;
  logic [31:0]   s1_a_r;
  logic [31:0]   s1_b_r;

  // result stage
  logic          s2_valid_r;
  logic [PW-1:0] s2_pc_r;
  logic          s2_halt_r;
  logic          s2_pv_r;
  logic [31:0]   s2_pval_r;
  logic          s2_ldw_r;
  logic [4:0]    s2_ldid_r;
  logic          s2_ret_r;
  logic [1:0]    s2_ba_r;
  logic [7:0]    bk_rd_r [4];

  // handshake
  logic s2_leave, advance, s1_fire, in_fire;
  assign s2_leave      = s2_valid_r & out_chan.ready;
  assign advance       = ~s2_valid_r | out_chan.ready;
  assign s1_fire       = s1_valid_r & advance;
  assign in_chan.ready = ~s1_valid_r | advance;
  assign in_fire       = in_chan.valid & in_chan.ready;

  // load data from the banks, little-endian
  logic [31:0]   ld_data;
  logic [PW-1:0] ret_pc;
  logic          ret_pend;
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ld_data[8*j +: 8] = bk_rd_r[s2_ba_r + 2'(j)];
    end
  end
  assign ret_pc   = ld_data[PW-1:0];
  assign ret_pend = s2_valid_r & s2_ret_r;

  // decode
  mxie_pkg::op_t op;
  logic [4:0]    r1, r2;
  logic [31:0]   imm;
  assign op  = mxie_pkg::op_t'(s1_word_r[31:27]);
  assign r1  = s1_word_r[26:22];
  assign r2  = s1_word_r[21:17];
  assign imm = {{16{s1_word_r[15]}}, s1_word_r[15:0]};

  // operands with forwarding of a pending load
  logic [31:0]   opa, opb, sp, fl;
  logic [PW-1:0] cur_pc;
  logic          cur_halt, exec;
  always_comb begin
    opa = (s2_valid_r && s2_ldw_r && s2_ldid_r == r1) ? ld_data : s1_a_r;
    opb = (s2_valid_r && s2_ldw_r && s2_ldid_r == r2) ? ld_data : s1_b_r;
    sp  = (s2_valid_r && s2_ldw_r && s2_ldid_r == 5'(mxie_pkg::SP_ID)) ?
          ld_data : rf_r[mxie_pkg::SP_ID];
    fl  = (s2_valid_r && s2_ldw_r && s2_ldid_r == 5'(mxie_pkg::FLAGS_ID)) ?
          ld_data : rf_r[mxie_pkg::FLAGS_ID];
  end
  assign cur_pc   = ret_pend ? ret_pc : pc_r;
  assign cur_halt = halt_r | (ret_pend && ret_pc == end_pc);
  assign exec     = ~cur_halt & (cur_pc != end_pc);

  // execute
  logic          rw_en;
  logic [4:0]    rw_id;
  logic [31:0]   rw_data;
  logic          mem_we, ldw, is_ret, ret_empty, taken, pv, halt_n;
  logic [4:0]    ldid;
  logic [31:0]   maddr, mdata, pval, diff, flags_v;
  logic [PW-1:0] nxt_pc;
  logic          sf, of, zf;

  assign sf = (fl & mxie_pkg::FLAG_SF) != '0;
  assign of = (fl & mxie_pkg::FLAG_OF) != '0;
  assign zf = (fl & mxie_pkg::FLAG_ZF) != '0;

  always_comb begin
    rw_en     = 1'b0;
    rw_id     = r1;
    rw_data   = '0;
    mem_we    = 1'b0;
    maddr     = '0;
    mdata     = '0;
    ldw       = 1'b0;
    ldid      = r2;
    is_ret    = 1'b0;
    ret_empty = 1'b0;
    taken     = 1'b0;
    pv        = 1'b0;
    pval      = '0;
    diff      = opb - opa;
    flags_v   = '0;
    if (((opb ^ opa) & (opb ^ diff)) >> 31 != '0) flags_v = flags_v | mxie_pkg::FLAG_OF;
    if (diff[31])                               flags_v = flags_v | mxie_pkg::FLAG_SF;
    if (diff == '0)                             flags_v = flags_v | mxie_pkg::FLAG_ZF;
    if (opa > opb)                              flags_v = flags_v | mxie_pkg::FLAG_CF;

    unique case (op)
      mxie_pkg::OP_SUBI: begin
        rw_en = 1'b1; rw_data = opa - imm;
      end
      mxie_pkg::OP_ADD: begin
        rw_en = 1'b1; rw_id = r2; rw_data = opa + opb;
      end
      mxie_pkg::OP_ADDI: begin
        rw_en = 1'b1; rw_data = opa + imm;
      end
      mxie_pkg::OP_MUL: begin
        rw_en = 1'b1; rw_id = r2; rw_data = opa * opb;
      end
      mxie_pkg::OP_SHR: begin
        rw_en = 1'b1; rw_data = opa >> 1;
      end
      mxie_pkg::OP_MOV: begin
        rw_en = 1'b1; rw_id = r2; rw_data = opa;
      end
      mxie_pkg::OP_LOAD: begin
        maddr = opa + imm; ldw = 1'b1; ldid = r2;
      end
      mxie_pkg::OP_STORE: begin
        maddr = opb + imm; mdata = opa; mem_we = 1'b1;
      end
      mxie_pkg::OP_IMM: begin
        rw_en = 1'b1; rw_data = imm;
      end
      mxie_pkg::OP_CMP: begin
        rw_en = 1'b1; rw_id = 5'(mxie_pkg::FLAGS_ID); rw_data = flags_v;
      end
      mxie_pkg::OP_JE:  taken = zf;
      mxie_pkg::OP_JL:  taken = sf != of;
      mxie_pkg::OP_JLE: taken = (sf != of) || zf;
      mxie_pkg::OP_JGE: taken = sf == of;
      mxie_pkg::OP_JBE: taken = (fl & (mxie_pkg::FLAG_CF | mxie_pkg::FLAG_ZF)) != '0;
      mxie_pkg::OP_JMP: taken = 1'b1;
      mxie_pkg::OP_CALL: begin
        rw_en = 1'b1; rw_id = 5'(mxie_pkg::SP_ID); rw_data = sp - 32'd4;
        maddr = sp - 32'd4; mdata = 32'(cur_pc) + 32'd4; mem_we = 1'b1;
        taken = 1'b1;
      end
      mxie_pkg::OP_RET: begin
        if (sp == 32'(MEM_BYTES)) begin
          ret_empty = 1'b1;
        end else begin
          is_ret = 1'b1; maddr = sp;
          rw_en = 1'b1; rw_id = 5'(mxie_pkg::SP_ID); rw_data = sp + 32'd4;
        end
      end
      mxie_pkg::OP_PUSH: begin
        rw_en = 1'b1; rw_id = 5'(mxie_pkg::SP_ID); rw_data = sp - 32'd4;
        maddr = sp - 32'd4; mdata = opa; mem_we = 1'b1;
      end
      mxie_pkg::OP_POP: begin
        maddr = sp; ldw = 1'b1; ldid = r1;
        rw_en = 1'b1; rw_id = 5'(mxie_pkg::SP_ID); rw_data = sp + 32'd4;
      end
      mxie_pkg::OP_PRINT: begin
        pv = 1'b1; pval = opa;
      end
      mxie_pkg::OP_READ: begin
        rw_en = 1'b1; rw_data = s1_rv_r;
      end
      default: ;
    endcase

    // next PC and halt
    if (!exec) begin
      nxt_pc = cur_pc;
    end else if (ret_empty) begin
      nxt_pc = cur_pc;
    end else if (taken) begin
      nxt_pc = cur_pc + PW'(4) + imm[PW-1:0];
    end else begin
      nxt_pc = cur_pc + PW'(4);
    end
    halt_n = ~exec | ret_empty | (nxt_pc == end_pc);
  end

  // write enables, gated by execution
  logic rf_we, mem_wr, ld_ok;
  assign rf_we  = s1_fire & exec & rw_en & (rw_id < 5'(mxie_pkg::NREGS));
  assign mem_wr = s1_fire & exec & mem_we;
  assign ld_ok  = exec & ldw & (ldid < 5'(mxie_pkg::NREGS));

  // operand capture at transfer, with writes landing on the same edge
  logic [4:0]  in_r1, in_r2;
  logic [31:0] cap_a, cap_b;
  assign in_r1 = in_chan.instruction_word[26:22];
  assign in_r2 = in_chan.instruction_word[21:17];
  always_comb begin
    if (in_r1 >= 5'(mxie_pkg::NREGS))                   cap_a = '0;
    else if (rf_we && rw_id == in_r1)                   cap_a = rw_data;
    else if (s2_leave && s2_ldw_r && s2_ldid_r == in_r1) cap_a = ld_data;
    else                                                cap_a = rf_r[in_r1];
    if (in_r2 >= 5'(mxie_pkg::NREGS))                   cap_b = '0;
    else if (rf_we && rw_id == in_r2)                   cap_b = rw_data;
    else if (s2_leave && s2_ldw_r && s2_ldid_r == in_r2) cap_b = ld_data;
    else                                                cap_b = rf_r[in_r2];
  end

  // execute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_fire) begin
      s1_word_r <= in_chan.instruction_word;
      s1_rv_r   <= in_chan.read_value;
      s1_a_r    <= cap_a;
      s1_b_r    <= cap_b;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_ldw_r   <= 1'b0;
      s2_ret_r   <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
      s2_ldw_r   <= s1_valid_r & ld_ok;
      s2_ret_r   <= s1_valid_r & exec & is_ret;
    end
    if (s1_fire) begin
      s2_pc_r   <= nxt_pc;
      s2_halt_r <= halt_n;
      s2_pv_r   <= exec & pv;
      s2_pval_r <= exec ? pval : '0;
      s2_ldid_r <= ldid;
      s2_ba_r   <= maddr[1:0];
    end
  end

  // PC, halt and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      halt_r <= 1'b0;
      for (int i = 0; i < mxie_pkg::NREGS; i++) begin
        rf_r[i] <= (i == mxie_pkg::SP_ID) ? 32'(MEM_BYTES) : '0;
      end
    end else begin
      if (s1_fire) begin
        pc_r   <= (exec && is_ret) ? cur_pc : nxt_pc;
        halt_r <= (exec && is_ret) ? cur_halt : halt_n;
      end else if (s2_leave && ret_pend) begin
        pc_r   <= ret_pc;
        halt_r <= cur_halt;
      end
      if (s2_leave && s2_ldw_r) begin
        rf_r[s2_ldid_r] <= ld_data;
      end
      if (rf_we) begin
        rf_r[rw_id] <= rw_data;
      end
    end
  end

  // stack memory: four byte banks, one word spread across them
  logic [AW-1:0] ba;
  assign ba = maddr[AW-1:0];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    j;
    logic [AW-1:0] baddr;
    logic [RW-1:0] row;
    logic [31:0]   wsh;

    assign j     = 2'(k) - ba[1:0];
    assign baddr = ba + AW'(j);
    assign row   = baddr[AW-1:2];
    assign wsh   = mdata >> {j, 3'b000};

    always_ff @(posedge clk) begin
      if (mem_wr) begin
        mem[row] <= wsh[7:0];
      end
      if (s1_fire) begin
        bk_rd_r[k] <= mem[row];
      end
    end
  end

  // result channel
  assign out_chan.valid       = s2_valid_r;
  assign out_chan.next_pc     = s2_ret_r ? ret_pc : s2_pc_r;
  assign out_chan.halted      = s2_ret_r ? (ret_pc == end_pc) : s2_halt_r;
  assign out_chan.print_valid = s2_pv_r;
  assign out_chan.print_value = s2_pval_r;

  // checks
  `MXIE_ASSERT(a_halt_sticky, halt_r |=> halt_r, "halt flag dropped without reset")
  `MXIE_ASSERT(a_in_moves_s1, (in_fire && s1_valid_r) |-> s1_fire, "execute item overwritten")
  `MXIE_ASSERT(a_idle_step_halts, (s1_fire && !exec) |=> (s2_valid_r && s2_halt_r && !s2_pv_r), "skipped step did not report halt")
  `MXIE_ASSERT(a_ret_commit, (s2_leave && ret_pend && !s1_fire) |=> (pc_r == $past(ret_pc)), "ret target not committed to PC")
  `MXIE_ASSERT_ALWAYS(a_ret_no_load, s2_ret_r |-> !s2_ldw_r, "ret and load pending together")

endmodule

// File: bench/tb_top.sv
module tb_top;

  localparam int MEM_SIZE = 1024;
  localparam int LATENCY  = 2;
  localparam int PCW      = mxie_pkg::PC_W;

  typedef struct packed {
    logic [PCW-1:0] next_pc;
    logic           print_valid;
    logic [31:0]    print_value;
    logic           halted;
  } step_res_t;

  // Executor state mirror plus the queue of results still owed by the block
  class mxie_scoreboard_t;
    logic [PCW-1:0] pc;
    logic [31:0]    rf[mxie_pkg::NREGS];
    logic [7:0]     mem[MEM_SIZE];
    bit             written[MEM_SIZE];
    bit             halt;
    logic [15:0]    prog_len;
    step_res_t      owed[$];
    int             mismatches;

    function void clear();
      pc = '0;
      halt = 0;
      prog_len = '0;
      for (int i = 0; i < mxie_pkg::NREGS; i++) rf[i] = '0;
      rf[mxie_pkg::SP_ID] = MEM_SIZE;
      for (int i = 0; i < MEM_SIZE; i++) begin
        mem[i] = '0;
        written[i] = 0;
      end
      owed.delete();
    endfunction

    function logic [31:0] rd(logic [4:0] id);
      return (id < mxie_pkg::NREGS) ? rf[id] : 32'h0;
    endfunction

    // little-endian word read; flags any byte never stored since reset
    function logic [31:0] load_word(logic [31:0] addr, inout bit unread);
      logic [31:0] v;
      logic [9:0]  idx;
      v = '0;
      for (int k = 0; k < 4; k++) begin
        idx = addr[9:0] + k[9:0];
        if (!written[idx]) unread = 1;
        v[8*k +: 8] = mem[idx];
      end
      return v;
    endfunction

    function void store_word(logic [31:0] addr, logic [31:0] v);
      logic [9:0] idx;
      for (int k = 0; k < 4; k++) begin
        idx = addr[9:0] + k[9:0];
        mem[idx] = v[8*k +: 8];
        written[idx] = 1;
      end
    endfunction

    // One instruction; state changes only when commit is set.
    // Returns 1 if the instruction would read stack bytes never written.
    function bit execute(logic [31:0] w, logic [31:0] rv, bit commit, output step_res_t r);
      logic [4:0]     op, r1, r2;
      logic [31:0]    imm, fl, a, b, d, v, sp, rval, maddr, mval;
      logic [PCW-1:0] end_pc, nxt, target;
      bit             unread, taken, reg_en, mem_en, flag_en, new_halt;
      logic [4:0]     reg_id;
      op = w[31:27];
      r1 = w[26:22];
      r2 = w[21:17];
      imm = {{16{w[15]}}, w[15:0]};
      end_pc = {prog_len, 2'b00};
      nxt = pc + PCW'(4);
      target = pc + PCW'(4) + imm[PCW-1:0];
      fl = rf[mxie_pkg::FLAGS_ID];
      sp = rf[mxie_pkg::SP_ID];
      unread = 0;
      taken = 0;
      reg_en = 0;
      mem_en = 0;
      flag_en = 0;
      new_halt = 0;
      reg_id = '0;
      rval = '0;
      maddr = '0;
      mval = '0;
      r = '0;
      if (halt || pc == end_pc) begin
        r.next_pc = pc;
        r.halted = 1;
        if (commit) halt = 1;
        return 0;
      end
      case (op)
        mxie_pkg::OP_SUBI: begin reg_en = 1; reg_id = r1; rval = rd(r1) - imm; end
        mxie_pkg::OP_ADD:  begin reg_en = 1; reg_id = r2; rval = rd(r1) + rd(r2); end
        mxie_pkg::OP_ADDI: begin reg_en = 1; reg_id = r1; rval = rd(r1) + imm; end
        mxie_pkg::OP_MUL:  begin reg_en = 1; reg_id = r2; rval = rd(r1) * rd(r2); end
        mxie_pkg::OP_SHR:  begin reg_en = 1; reg_id = r1; rval = rd(r1) >> 1; end
        mxie_pkg::OP_MOV:  begin reg_en = 1; reg_id = r2; rval = rd(r1); end
        mxie_pkg::OP_LOAD: begin
          reg_en = 1;
          reg_id = r2;
          rval = load_word(rd(r1) + imm, unread);
        end
        mxie_pkg::OP_STORE: begin
          mem_en = 1; maddr = rd(r2) + imm; mval = rd(r1);
        end
        mxie_pkg::OP_IMM:  begin reg_en = 1; reg_id = r1; rval = imm; end
        mxie_pkg::OP_CMP: begin
          a = rd(r1);
          b = rd(r2);
          d = b - a;
          v = '0;
          if (((b ^ a) & (b ^ d)) >> 31) v |= mxie_pkg::FLAG_OF;
          if (d[31]) v |= mxie_pkg::FLAG_SF;
          if (d == 0) v |= mxie_pkg::FLAG_ZF;
          if (a > b) v |= mxie_pkg::FLAG_CF;
          flag_en = 1;
          fl = v;
        end
        mxie_pkg::OP_JE:  taken = (fl & mxie_pkg::FLAG_ZF) != 0;
        mxie_pkg::OP_JL:
          taken = ((fl & mxie_pkg::FLAG_SF) != 0) != ((fl & mxie_pkg::FLAG_OF) != 0);
        mxie_pkg::OP_JLE:
          taken = (((fl & mxie_pkg::FLAG_SF) != 0) != ((fl & mxie_pkg::FLAG_OF) != 0)) ||
                  ((fl & mxie_pkg::FLAG_ZF) != 0);
        mxie_pkg::OP_JGE:
          taken = ((fl & mxie_pkg::FLAG_SF) != 0) == ((fl & mxie_pkg::FLAG_OF) != 0);
        mxie_pkg::OP_JBE: taken = (fl & (mxie_pkg::FLAG_CF | mxie_pkg::FLAG_ZF)) != 0;
        mxie_pkg::OP_JMP: taken = 1;
        mxie_pkg::OP_CALL: begin
          sp = sp - 4;
          mem_en = 1;
          maddr = sp;
          mval = 32'(pc) + 32'd4;
          taken = 1;
        end
        mxie_pkg::OP_RET: begin
          if (sp == MEM_SIZE) begin
            new_halt = 1;
            nxt = pc;
          end else begin
            v = load_word(sp, unread);
            nxt = v[PCW-1:0];
            sp = sp + 4;
          end
        end
        mxie_pkg::OP_PUSH: begin
          mval = rd(r1);
          sp = sp - 4;
          mem_en = 1;
          maddr = sp;
        end
        mxie_pkg::OP_POP: begin
          rval = load_word(sp, unread);
          sp = sp + 4;
          reg_en = 1;
          reg_id = r1;
        end
        mxie_pkg::OP_PRINT: begin r.print_valid = 1; r.print_value = rd(r1); end
        mxie_pkg::OP_READ:  begin reg_en = 1; reg_id = r1; rval = rv; end
        default: ;
      endcase
      if (taken) nxt = target;
      if (nxt == end_pc) new_halt = 1;
      r.next_pc = nxt;
      r.halted = new_halt;
      if (commit) begin
        rf[mxie_pkg::SP_ID] = sp;
        if (flag_en) rf[mxie_pkg::FLAGS_ID] = fl;
        if (reg_en && reg_id < mxie_pkg::NREGS) rf[reg_id] = rval;
        if (mem_en) store_word(maddr, mval);
        pc = nxt;
        halt = new_halt;
      end
      return unread;
    endfunction

    function void note_transfer(logic [31:0] w, logic [31:0] rv);
      step_res_t r;
      void'(execute(w, rv, 1, r));
      owed.push_back(r);
    endfunction

    function void check_result(step_res_t got);
      step_res_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result pc=%h print=%0b/%h halt=%0b",
                   got.next_pc, got.print_valid, got.print_value, got.halted);
        return;
      end
      want = owed.pop_front();
      if (got.next_pc !== want.next_pc || got.print_valid !== want.print_valid ||
          got.print_value !== want.print_value || got.halted !== want.halted) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result mismatch exp pc=%h print=%0b/%h halt=%0b ",
                    "act pc=%h print=%0b/%h halt=%0b"},
                   want.next_pc, want.print_valid, want.print_value, want.halted,
                   got.next_pc, got.print_valid, got.print_value, got.halted);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  mxie_in_if  in_if();
  mxie_out_if out_if();

  mini_x86_instruction_executor #(.MEM_BYTES(MEM_SIZE)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_if),
    .out_chan   (out_if)
  );

  mxie_scoreboard_t sb;
  int          send_idle_pct;
  int          sink_stall_pct;
  int          hold_cycles;
  logic [31:0] store_addrs[$];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // result side: ready at the falling edge, long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_if.ready = !($urandom_range(99) < sink_stall_pct);
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.next_pc, out_if.print_valid, out_if.print_value,
                       out_if.halted});
  end

  task automatic send_instr(logic [31:0] w, logic [31:0] rv);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.instruction_word = w;
    in_if.read_value = rv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_transfer(w, rv);
  endtask

  function automatic logic [31:0] instr(mxie_pkg::op_t op, logic [4:0] r1, logic [4:0] r2,
                                        logic [15:0] imm);
    return {op, r1, r2, 1'b0, imm};
  endfunction

  // random instruction that reads only stored bytes and, unless allowed, does not halt
  task automatic send_random(bit allow_halt);
    logic [31:0] w, rv, t;
    logic [4:0]  op, r1, r2;
    logic [15:0] imm;
    int          x, k;
    step_res_t   r;
    bit          ok;
    ok = 0;
    for (int tries = 0; tries < 64 && !ok; tries++) begin
      x = $urandom_range(99);
      if (x < 5) op = 5'($urandom_range(31, 22));
      else if (x < 35) op = 5'($urandom_range(mxie_pkg::OP_POP, mxie_pkg::OP_CALL));
      else if (x < 45) op = 5'($urandom_range(mxie_pkg::OP_STORE, mxie_pkg::OP_LOAD));
      else op = 5'($urandom_range(mxie_pkg::OP_READ, mxie_pkg::OP_SUBI));
      r1 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
      r2 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
      imm = 16'($urandom);
      k = $urandom_range(63);
      k = k - 32;
      if (op == mxie_pkg::OP_LOAD && store_addrs.size() > 0 && $urandom_range(3) != 0) begin
        t = store_addrs[$urandom_range(store_addrs.size() - 1)];
        imm = 16'(((t - sb.rd(r1)) & 32'h3FF) + 32'(k * 1024));
      end else if (op == mxie_pkg::OP_STORE) begin
        t = $urandom_range(MEM_SIZE - 1);
        imm = 16'(((t - sb.rd(r2)) & 32'h3FF) + 32'(k * 1024));
      end else if (op >= mxie_pkg::OP_JE && op <= mxie_pkg::OP_CALL &&
                   $urandom_range(1) == 0) begin
        imm = 16'($urandom_range(128) - 64);
      end
      w = {op, r1, r2, 1'($urandom), imm};
      rv = $urandom;
      ok = !sb.execute(w, rv, 0, r) && (allow_halt || !r.halted);
    end
    if (!ok) begin
      w = instr(mxie_pkg::OP_IMM, 5'd20, 5'd0, 16'h0);
      rv = '0;
    end
    if (ok && op == mxie_pkg::OP_STORE) begin
      store_addrs.push_back(sb.rd(r2) + {{16{imm[15]}}, imm});
      if (store_addrs.size() > 16) void'(store_addrs.pop_front());
    end
    send_instr(w, rv);
  endtask

  // wait for all owed results, let the pipeline settle, then write the register
  task automatic write_prog_len(logic [15:0] len);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = len;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.prog_len = len;
  endtask

  initial begin
    sb = new();
    sb.mismatches = 0;
    sb.clear();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.instruction_word = '0;
    in_if.read_value = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_prog_len(16'hFFFF);

    // directed: every operation, field extremes, wrapping and forwarding cases
    send_instr(instr(mxie_pkg::OP_IMM, 5'd1, 5'd0, 16'h7FFF), '0);
    send_instr(instr(mxie_pkg::OP_IMM, 5'd2, 5'd0, 16'h8000), '0);
    send_instr(instr(mxie_pkg::OP_ADD, 5'd1, 5'd2, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_SUBI, 5'd1, 5'd0, 16'hFFFF), '0);
    send_instr(instr(mxie_pkg::OP_ADDI, 5'd2, 5'd0, 16'h0001), '0);
    send_instr(instr(mxie_pkg::OP_MUL, 5'd1, 5'd2, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_SHR, 5'd2, 5'd0, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_MOV, 5'd1, 5'd3, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_CMP, 5'd1, 5'd2, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_JE, 5'd0, 5'd0, 16'h0008), '0);
    send_instr(instr(mxie_pkg::OP_JL, 5'd0, 5'd0, 16'h0004), '0);
    send_instr(instr(mxie_pkg::OP_JLE, 5'd0, 5'd0, 16'h000C), '0);
    send_instr(instr(mxie_pkg::OP_JGE, 5'd0, 5'd0, 16'h0010), '0);
    send_instr(instr(mxie_pkg::OP_JBE, 5'd0, 5'd0, 16'h0000), '0);
    send_instr(instr(mxie_pkg::OP_JMP, 5'd0, 5'd0, 16'h0008), '0);
    // word straddling the top of memory, loaded back right away
    send_instr(instr(mxie_pkg::OP_STORE, 5'd1, 5'd20, 16'h03FE), '0);
    send_instr(instr(mxie_pkg::OP_LOAD, 5'd20, 5'd4, 16'hFBFE), '0);
    // push of the stack pointer, then pop into it
    send_instr(instr(mxie_pkg::OP_PUSH, 5'd6, 5'd0, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_POP, 5'd6, 5'd0, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_CALL, 5'd0, 5'd0, 16'h0004), '0);
    send_instr(instr(mxie_pkg::OP_RET, 5'd0, 5'd0, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_READ, 5'd1, 5'd0, 16'h0), 32'h8000_0000);
    send_instr(instr(mxie_pkg::OP_READ, 5'd25, 5'd0, 16'h0), 32'hFFFF_FFFF);
    send_instr(instr(mxie_pkg::OP_PRINT, 5'd1, 5'd0, 16'h0), '0);
    send_instr(instr(mxie_pkg::OP_PRINT, 5'd31, 5'd0, 16'h0), '0);
    send_instr({5'd31, 27'h7FF_FFFF}, '0);

    // random phases with different idling and program lengths
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 84; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 84; end
        3: begin send_idle_pct = 8;  sink_stall_pct = 8;  end
        default: begin send_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      if (ph == 1) write_prog_len(16'($urandom_range(16'hFFFE, 1)));
      if (ph == 3) write_prog_len(16'($urandom_range(2000, 300)));
      if (ph == 4) write_prog_len(16'hFFFF);
      if (ph == 4) hold_cycles = 300;
      for (int i = 0; i < 385; i++) send_random(0);
    end

    // end of program: empty program length, then ret on an empty stack
    write_prog_len(16'h0000);
    send_idle_pct = 8;
    sink_stall_pct = 8;
    send_instr(instr(mxie_pkg::OP_IMM, 5'd6, 5'd0, 16'h0400), '0);
    send_instr(instr(mxie_pkg::OP_RET, 5'd0, 5'd0, 16'h0), '0);
    for (int i = 0; i < 6; i++) send_random(1);

    @(negedge clk);
    in_if.valid = 1'b0;
    sink_stall_pct = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 500000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
